// ===== rtl/motion_stall_detector_core_macros.svh =====
// Assertion macros shared by the motion stall detector RTL.
// Included by every module that carries concurrent checks; no other dependencies.
`ifndef MOTION_STALL_DETECTOR_CORE_MACROS_SVH
`define MOTION_STALL_DETECTOR_CORE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define MSD_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("msd: same-cycle check failed");
// next-cycle implication
`define MSD_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("msd: next-cycle check failed");
// condition that must never hold
`define MSD_ASSERT_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("msd: forbidden condition seen");
`else
`define MSD_ASSERT_IMP(name, clk, rst, ante, cons)
`define MSD_ASSERT_NXT(name, clk, rst, ante, cons)
`define MSD_ASSERT_NEVER(name, clk, rst, cond)
`endif

`endif

// ===== rtl/msd_pkg.sv =====
// Shared types and constants for the motion stall detector.
// No dependencies; used by the request interface, the evaluator and the top level.
package msd_pkg;

   // payload and register widths
   localparam int DIST_W     = 32;
   localparam int SPEED_W    = 16;
   localparam int FREQ_W     = 16;
   localparam int ABS_W      = 16;
   localparam int REL_W      = 9;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;

   // distance difference over the window, its product with the frequency, and the two limit widths
   localparam int REAL_W     = DIST_W + 1;
   localparam int PROD_W     = REAL_W + FREQ_W + 1;
   localparam int ABS_LIM_W  = ABS_W + FREQ_W;
   localparam int REL_LIM_W  = REL_W + PROD_W;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_UPDATE_FREQ = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ABS_THRESH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REL_THRESH  = 2'd2;

   // register reset values
   localparam logic [FREQ_W-1:0] UPDATE_FREQ_RST = 16'd100;
   localparam logic [ABS_W-1:0]  ABS_THRESH_RST  = 16'd5;
   localparam logic [REL_W-1:0]  REL_THRESH_RST  = 9'd128;

   typedef struct packed {
      logic [FREQ_W-1:0] update_freq_hz;
      logic [ABS_W-1:0]  abs_threshold_mm;
      logic [REL_W-1:0]  rel_threshold_q8;
   } cfg_type;

   typedef struct packed {
      logic start;
      logic take;
   } eval_ctl_type;

   typedef struct packed {
      logic done;
      logic blocked;
   } eval_sts_type;

endpackage

// ===== rtl/msd_req_if.sv =====
// Request channel of the motion stall detector: valid/ready plus one tick sample.
// Depends on msd_pkg for the field widths.
interface msd_req_if;
   import msd_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [DIST_W-1:0]  distance_mm;
   logic signed [SPEED_W-1:0] speed_mm_s;

   modport source (output valid, output distance_mm, output speed_mm_s, input ready);
   modport sink   (input valid, input distance_mm, input speed_mm_s, output ready);
endinterface

// Response channel of the motion stall detector: valid/ready plus the stall flag.
// Depends on nothing beyond plain logic.
interface msd_rsp_if;
   logic valid;
   logic ready;
   logic blocked;

   modport source (output valid, output blocked, input ready);
   modport sink   (input valid, input blocked, output ready);
endinterface

// ===== rtl/motion_stall_detector_core.sv =====
// Top level of the motion stall detector: ring memory, window sum and sequencing.
// Depends on msd_pkg, msd_req_if/msd_rsp_if, msd_ram, msd_eval and the macro header.
//
// Usage:
//   req_chan carries one control tick (distance_mm, speed_mm_s) per request;
//   rsp_chan returns exactly one blocked flag per request, in order.
//   csr_wr_en/csr_index/csr_wr_data write update_freq_hz (0), abs_threshold_mm (1)
//   and rel_threshold_q8 (2); write only while no request is in flight.
// Timing:
//   A request is accepted when req_chan.ready is high, i.e. when no other request
//   is in flight. The flag reaches rsp_chan through the ring read register, the
//   distance subtract, the multiply, magnitude, product and compare stages of the
//   evaluator and the output register; the next request can be taken in the same
//   cycle as the flag appears, so only one request is in the evaluator at a time.
//   The flag is 0 until the window has filled; a raised flag restarts the fill.
// Reset:
//   Synchronous, active high. Registers return to 100 / 5 / 128, the window sum,
//   slot and fill count clear, and ring entries not yet written read as zero.
// Stall:
//   A finished flag waits in the output register while rsp_chan.ready is low; a
//   new request may be accepted meanwhile, and its flag waits inside the evaluator.
`include "motion_stall_detector_core_macros.svh"

module motion_stall_detector_core #(
   parameter int WINDOW = 20
) (
   input  logic                               clock,
   input  logic                               reset,
   msd_req_if.sink                            req_chan,
   msd_rsp_if.source                          rsp_chan,
   input  logic                               csr_wr_en,
   input  logic [msd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [msd_pkg::CSR_DATA_W-1:0]     csr_wr_data
);
   import msd_pkg::*;

   localparam int SLOT_W = $clog2(WINDOW);
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int SUM_W  = SPEED_W + $clog2(WINDOW);
   localparam int RAM_W  = DIST_W + SPEED_W;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
   localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(WINDOW);

   cfg_type                   cfg_ff, cfg_in;
   logic                      busy_ff, busy_in;
   logic                      rd_vld_ff;
   logic [SLOT_W-1:0]         write_slot_ff, write_slot_in;
   logic                      lap_done_ff, lap_done_in;
   logic [FILL_W-1:0]         fill_ff, fill_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic signed [DIST_W-1:0]  dist_ff;
   logic signed [SPEED_W-1:0] speed_ff;
   logic                      check_ff;
   logic                      zero_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_blocked_ff, rsp_blocked_in;

   logic                      req_fire;
   logic                      take;
   logic                      blocked_res;
   logic [SLOT_W-1:0]         oldest_slot;
   logic [RAM_W-1:0]          ram_wr_data;
   logic [RAM_W-1:0]          ram_rd_data;
   logic [RAM_W-1:0]          old_entry;
   logic signed [DIST_W-1:0]  old_dist;
   logic signed [SPEED_W-1:0] old_speed;
   logic signed [REAL_W-1:0]  real_mm;
   eval_ctl_type              eval_ctl;
   eval_sts_type              eval_sts;

   assign req_chan.ready = ~busy_ff;
   assign req_fire       = req_chan.valid & ~busy_ff;
   assign oldest_slot    = (write_slot_ff == LAST_SLOT) ? '0 : write_slot_ff + 1'b1;
   assign ram_wr_data    = {req_chan.distance_mm, req_chan.speed_mm_s};

   // ring of past distances and speeds: write this tick, read the oldest
   msd_ram #(
      .WIDTH (RAM_W),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (req_fire),
      .wr_addr (write_slot_ff),
      .wr_data (ram_wr_data),
      .rd_en   (req_fire),
      .rd_addr (oldest_slot),
      .rd_data (ram_rd_data)
   );

   // drop unwritten entries to zero on the first lap after reset
   always_comb begin
      old_entry = zero_ff ? '0 : ram_rd_data;
      old_dist  = $signed(old_entry[RAM_W-1 -: DIST_W]);
      old_speed = $signed(old_entry[SPEED_W-1:0]);
      real_mm   = REAL_W'(dist_ff) - REAL_W'(old_dist);
   end

   // window sum: lose the oldest speed, gain the new one
   always_comb begin
      sum_in = sum_ff;
      if (rd_vld_ff) begin
         sum_in = sum_ff - SUM_W'(old_speed) + SUM_W'(speed_ff);
      end
   end

   assign eval_ctl.start = rd_vld_ff;
   assign eval_ctl.take  = take;

   msd_eval #(
      .SUM_W (SUM_W)
   ) u_eval (
      .clock     (clock),
      .reset     (reset),
      .ctl       (eval_ctl),
      .real_mm   (real_mm),
      .sum_speed (sum_ff),
      .cfg       (cfg_ff),
      .sts       (eval_sts)
   );

   assign take        = eval_sts.done & (~rsp_valid_ff | rsp_chan.ready);
   assign blocked_res = check_ff & eval_sts.blocked;

   // slot, lap, fill and busy sequencing
   always_comb begin
      write_slot_in = write_slot_ff;
      lap_done_in   = lap_done_ff;
      fill_in       = fill_ff;
      busy_in       = busy_ff;
      if (req_fire) begin
         write_slot_in = oldest_slot;
         lap_done_in   = lap_done_ff | (write_slot_ff == LAST_SLOT);
         busy_in       = 1'b1;
      end
      if (take) begin
         busy_in = 1'b0;
         if (!check_ff) begin
            fill_in = fill_ff + 1'b1;
         end else if (blocked_res) begin
            fill_in = '0;
         end
      end
   end

   // output register: load on take, drop when the receiver accepts
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_blocked_in = rsp_blocked_ff;
      if (take) begin
         rsp_valid_in   = 1'b1;
         rsp_blocked_in = blocked_res;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_UPDATE_FREQ: cfg_in.update_freq_hz   = csr_wr_data[FREQ_W-1:0];
            CSR_ABS_THRESH:  cfg_in.abs_threshold_mm = csr_wr_data[ABS_W-1:0];
            CSR_REL_THRESH:  cfg_in.rel_threshold_q8 = csr_wr_data[REL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.update_freq_hz   <= UPDATE_FREQ_RST;
         cfg_ff.abs_threshold_mm <= ABS_THRESH_RST;
         cfg_ff.rel_threshold_q8 <= REL_THRESH_RST;
         busy_ff                 <= 1'b0;
         rd_vld_ff               <= 1'b0;
         write_slot_ff           <= '0;
         lap_done_ff             <= 1'b0;
         fill_ff                 <= '0;
         sum_ff                  <= '0;
         rsp_valid_ff            <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         busy_ff       <= busy_in;
         rd_vld_ff     <= req_fire;
         write_slot_ff <= write_slot_in;
         lap_done_ff   <= lap_done_in;
         fill_ff       <= fill_in;
         sum_ff        <= sum_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // hold the request and its window status while it is in flight
   always_ff @(posedge clock) begin
      if (req_fire) begin
         dist_ff  <= req_chan.distance_mm;
         speed_ff <= req_chan.speed_mm_s;
         check_ff <= (fill_ff == FULL_FILL);
         zero_ff  <= ~lap_done_ff & (oldest_slot != '0);
      end
      rsp_blocked_ff <= rsp_blocked_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.blocked = rsp_blocked_ff;

   `MSD_ASSERT_NEVER(a_fill_range, clock, reset, fill_ff > FULL_FILL)
   `MSD_ASSERT_NEVER(a_slot_range, clock, reset, write_slot_ff > LAST_SLOT)
   `MSD_ASSERT_NXT(a_read_follows, clock, reset, req_fire, rd_vld_ff && busy_ff)
   `MSD_ASSERT_NXT(a_flag_restarts, clock, reset, take && blocked_res, fill_ff == '0)
endmodule

// ===== rtl/msd_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies; holds the distance and speed rings of the detector.
module msd_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 20
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic                                 rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/msd_eval.sv =====
// Stall evaluator: pipelined error and threshold arithmetic for one request.
// Depends on msd_pkg and the assertion macro header.
`include "motion_stall_detector_core_macros.svh"

module msd_eval #(
   parameter int SUM_W = 21
) (
   input  logic                              clock,
   input  logic                              reset,
   input  msd_pkg::eval_ctl_type             ctl,
   input  logic signed [msd_pkg::REAL_W-1:0] real_mm,
   input  logic signed [SUM_W-1:0]           sum_speed,
   input  msd_pkg::cfg_type                  cfg,
   output msd_pkg::eval_sts_type             sts
);
   import msd_pkg::*;

   // stage valids
   logic a_vld_ff, a_vld_in;
   logic b_vld_ff, b_vld_in;
   logic c_vld_ff, c_vld_in;
   logic d_vld_ff, d_vld_in;
   logic e_vld_ff, e_vld_in;
   logic [4:0] vld_vec;

   // stage payloads
   logic signed [REAL_W-1:0]  a_real_ff;
   logic signed [SUM_W-1:0]   a_sum_ff;
   logic signed [PROD_W-1:0]  b_prod_ff, b_prod_in;
   logic signed [SUM_W-1:0]   b_sum_ff;
   logic [ABS_LIM_W-1:0]      b_abs_lim_ff, b_abs_lim_in;
   logic [PROD_W-1:0]         c_err_ff, c_err_in;
   logic [PROD_W-1:0]         c_big_ff, c_big_in;
   logic [ABS_LIM_W-1:0]      c_abs_lim_ff;
   logic                      d_abs_hit_ff, d_abs_hit_in;
   logic [REL_LIM_W-1:0]      d_err_sh_ff, d_err_sh_in;
   logic [REL_LIM_W-1:0]      d_rel_lim_ff, d_rel_lim_in;
   logic                      e_blocked_ff, e_blocked_in;

   logic signed [FREQ_W:0]    freq_s;
   logic signed [PROD_W-1:0]  sum_ext;
   logic signed [PROD_W-1:0]  diff;
   logic [PROD_W-1:0]         mag_s;
   logic [PROD_W-1:0]         mag_p;

   // advance the one-hot progress of the single request in flight
   always_comb begin
      a_vld_in = ctl.start;
      b_vld_in = a_vld_ff;
      c_vld_in = b_vld_ff;
      d_vld_in = c_vld_ff;
      e_vld_in = d_vld_ff | (e_vld_ff & ~ctl.take);
   end

   // stage B: scale the travelled distance by the tick rate and form the absolute limit
   always_comb begin
      freq_s       = $signed({1'b0, cfg.update_freq_hz});
      b_prod_in    = a_real_ff * freq_s;
      b_abs_lim_in = cfg.abs_threshold_mm * cfg.update_freq_hz;
   end

   // stage C: error magnitude and the larger of the two magnitudes
   always_comb begin
      sum_ext  = PROD_W'(b_sum_ff);
      diff     = sum_ext - b_prod_ff;
      c_err_in = diff[PROD_W-1] ? PROD_W'(-diff) : PROD_W'(diff);
      mag_s    = sum_ext[PROD_W-1] ? PROD_W'(-sum_ext) : PROD_W'(sum_ext);
      mag_p    = b_prod_ff[PROD_W-1] ? PROD_W'(-b_prod_ff) : PROD_W'(b_prod_ff);
      c_big_in = (mag_s > mag_p) ? mag_s : mag_p;
   end

   // stage D: absolute test and the relative limit product
   always_comb begin
      d_abs_hit_in = c_err_ff > PROD_W'(c_abs_lim_ff);
      d_err_sh_in  = {1'b0, c_err_ff, 8'b0};
      d_rel_lim_in = cfg.rel_threshold_q8 * c_big_ff;
   end

   // stage E: combine both tests, hold until taken
   always_comb begin
      e_blocked_in = e_blocked_ff;
      if (d_vld_ff) begin
         e_blocked_in = d_abs_hit_ff & (d_err_sh_ff > d_rel_lim_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
         b_vld_ff <= b_vld_in;
         c_vld_ff <= c_vld_in;
         d_vld_ff <= d_vld_in;
         e_vld_ff <= e_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      a_real_ff    <= real_mm;
      a_sum_ff     <= sum_speed;
      b_prod_ff    <= b_prod_in;
      b_sum_ff     <= a_sum_ff;
      b_abs_lim_ff <= b_abs_lim_in;
      c_err_ff     <= c_err_in;
      c_big_ff     <= c_big_in;
      c_abs_lim_ff <= b_abs_lim_ff;
      d_abs_hit_ff <= d_abs_hit_in;
      d_err_sh_ff  <= d_err_sh_in;
      d_rel_lim_ff <= d_rel_lim_in;
      e_blocked_ff <= e_blocked_in;
   end

   assign sts.done    = e_vld_ff;
   assign sts.blocked = e_blocked_ff;
   assign vld_vec     = {a_vld_ff, b_vld_ff, c_vld_ff, d_vld_ff, e_vld_ff};

   `MSD_ASSERT_NEVER(a_one_in_flight, clock, reset, $countones(vld_vec) > 1)
   `MSD_ASSERT_NXT(a_start_enters, clock, reset, ctl.start, a_vld_ff)
   `MSD_ASSERT_NXT(a_done_holds, clock, reset, e_vld_ff && !ctl.take, e_vld_ff)
endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for motion_stall_detector_core: drives control ticks,
// predicts the stall flag for each one and checks every response in order.
// Depends on msd_pkg, msd_req_if/msd_rsp_if and the detector RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import msd_pkg::*;

   localparam int WINDOW_LEN  = 20;
   localparam int CYCLE_LIMIT = 500_000;
   localparam int MAX_REPORTS = 10;
   localparam int CSR_PAD_W   = CSR_DATA_W - REL_W;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   msd_req_if req_chan ();
   msd_rsp_if rsp_chan ();

   motion_stall_detector_core #(.WINDOW(WINDOW_LEN)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // predictor copy of the registers and the window state
   logic [FREQ_W-1:0]          cfg_freq;
   logic [ABS_W-1:0]           cfg_abs;
   logic [REL_W-1:0]           cfg_rel;
   logic signed [DIST_W-1:0]   dist_hist [WINDOW_LEN];
   logic signed [SPEED_W-1:0]  speed_hist [WINDOW_LEN];
   longint                     speed_sum;
   int                         slot;
   int                         filled;

   // flags still owed by the block, oldest first
   logic                       expected_flags [$];
   logic                       flag_want;
   int                         failures;
   int                         responses;
   int                         cycles;

   // idling controls
   logic                       req_idle;
   logic                       rsp_idle;
   logic                       rsp_hold;
   logic                       hold_go;
   int                         hold_cycles;
   int                         rsp_gap_left;

   // stimulus state: running odometer of the simulated base
   logic signed [DIST_W-1:0]   odometer;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // end the run once the cycle limit is passed
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d flags outstanding", cycles,
                  expected_flags.size());
         $display("FAILURE");
         $finish;
      end
   end

   // check each response against the oldest expected flag, then drive ready
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_flags.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("unexpected response %0d: blocked=%0b", responses, rsp_chan.blocked);
         end else begin
            flag_want = expected_flags.pop_front();
            if (rsp_chan.blocked !== flag_want) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $display("mismatch on response %0d: blocked expected %0b, got %0b",
                           responses, flag_want, rsp_chan.blocked);
            end
         end
         responses++;
      end
      if (rsp_hold) begin
         rsp_chan.ready <= 1'b0;
      end else if (rsp_gap_left > 0) begin
         rsp_gap_left--;
         rsp_chan.ready <= 1'b0;
      end else if (rsp_idle && $urandom_range(0, 7) == 0) begin
         rsp_gap_left = $urandom_range(0, 14);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // hold the receiver off for a counted stretch on request
   initial begin
      forever begin
         wait (hold_go);
         rsp_hold = 1'b1;
         repeat (hold_cycles) @(posedge clock);
         rsp_hold = 1'b0;
         hold_go  = 1'b0;
      end
   end

   // advance the predicted window by one tick and return the stall flag
   function automatic logic predict_stall(input logic signed [DIST_W-1:0] dist_mm,
                                          input logic signed [SPEED_W-1:0] speed);
      int     oldest;
      longint travel;
      longint scaled;
      longint err;
      longint mag_sum;
      longint mag_scaled;
      longint biggest;
      logic   stall;
      oldest = (slot + 1) % WINDOW_LEN;
      stall  = 1'b0;
      dist_hist[slot] = dist_mm;
      if (filled >= WINDOW_LEN) begin
         travel     = longint'(dist_mm) - longint'(dist_hist[oldest]);
         scaled     = travel * longint'(cfg_freq);
         err        = speed_sum - scaled;
         err        = (err < 0) ? -err : err;
         mag_sum    = (speed_sum < 0) ? -speed_sum : speed_sum;
         mag_scaled = (scaled < 0) ? -scaled : scaled;
         biggest    = (mag_sum > mag_scaled) ? mag_sum : mag_scaled;
         if (err > longint'(cfg_abs) * longint'(cfg_freq) &&
             err * 256 > longint'(cfg_rel) * biggest) begin
            stall  = 1'b1;
            filled = 0;
         end
      end else begin
         filled++;
      end
      speed_sum = speed_sum - longint'(speed_hist[oldest]) + longint'(speed);
      speed_hist[slot] = speed;
      slot = oldest;
      return stall;
   endfunction

   // offer one request, wait for acceptance and record its expected flag
   task automatic send_tick(input logic signed [DIST_W-1:0] dist_mm,
                            input logic signed [SPEED_W-1:0] speed);
      if (req_idle && $urandom_range(0, 5) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.distance_mm <= dist_mm;
      req_chan.speed_mm_s  <= speed;
      do @(posedge clock); while (!req_chan.ready);
      expected_flags.push_back(predict_stall(dist_mm, speed));
   endtask

   // stop sending and wait until every expected flag has come back
   task automatic drain_requests();
      req_chan.valid <= 1'b0;
      while (expected_flags.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // write all three registers back to back; call only while drained
   task automatic set_config(input logic [FREQ_W-1:0] freq, input logic [ABS_W-1:0] abs_mm,
                             input logic [REL_W-1:0] rel_q8);
      logic [CSR_PAD_W-1:0] pad;
      pad = CSR_PAD_W'($urandom_range(0, 127));
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_UPDATE_FREQ;
      csr_wr_data <= freq;
      @(posedge clock);
      csr_index   <= CSR_ABS_THRESH;
      csr_wr_data <= abs_mm;
      @(posedge clock);
      csr_index   <= CSR_REL_THRESH;
      csr_wr_data <= {pad, rel_q8};
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cfg_freq = freq;
      cfg_abs  = abs_mm;
      cfg_rel  = rel_q8;
   endtask

   // drive a base that alternates between moving freely and stalling
   task automatic run_motion(input int ticks);
      int     seg_left;
      logic   stalled;
      int     fraction;
      int     speed;
      longint step;
      seg_left = 0;
      stalled  = 1'b0;
      fraction = 4;
      speed    = 0;
      for (int i = 0; i < ticks; i++) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(5, 60);
            stalled  = ($urandom_range(0, 2) == 0);
            fraction = $urandom_range(0, 4);
            case ($urandom_range(0, 9))
               0: speed = -32768;
               1: speed = 32767;
               default: speed = int'($urandom_range(0, 6000)) - 3000;
            endcase
         end
         if ($urandom_range(0, 99) < 12) begin
            // noise: arbitrary distance and speed
            send_tick($urandom, SPEED_W'($urandom_range(0, 65535)));
         end else begin
            if (cfg_freq == '0)
               step = $urandom_range(0, 20);
            else
               step = longint'(speed) / longint'(cfg_freq) + longint'($urandom_range(0, 2)) - 1;
            if (stalled)
               step = step * fraction / 4;
            odometer = odometer + step[DIST_W-1:0];
            send_tick(odometer, speed[SPEED_W-1:0]);
         end
         seg_left--;
      end
   endtask

   // corner values of both fields, through the gathering phase and past it
   task automatic test_field_extremes();
      logic signed [DIST_W-1:0]  dist_corner [4];
      logic signed [SPEED_W-1:0] speed_corner [4];
      dist_corner  = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sh1};
      speed_corner = '{16'sh8000, 16'sh7FFF, 16'sh0, -16'sh1};
      for (int i = 0; i < 25; i++)
         send_tick(dist_corner[i % 4], speed_corner[(i / 4) % 4]);
      drain_requests();
   endtask

   // keep offering requests while the receiver holds off for a long stretch
   task automatic test_receiver_backlog();
      hold_cycles = 400;
      hold_go     = 1'b1;
      run_motion(40);
      drain_requests();
   endtask

   // walk through register settings, pausing the sender inside each phase
   task automatic test_config_phases();
      logic [FREQ_W-1:0] freq;
      logic [ABS_W-1:0]  abs_mm;
      logic [REL_W-1:0]  rel_q8;
      for (int phase = 0; phase < 12; phase++) begin
         case (phase)
            0: begin freq = 16'd100;   abs_mm = 16'd5;     rel_q8 = 9'd128; end
            1: begin freq = 16'd1;     abs_mm = 16'd0;     rel_q8 = 9'd0;   end
            2: begin freq = 16'd65535; abs_mm = 16'd65535; rel_q8 = 9'd256; end
            3: begin freq = 16'd0;     abs_mm = 16'd10;    rel_q8 = 9'd300; end
            4: begin freq = 16'd1000;  abs_mm = 16'd0;     rel_q8 = 9'd511; end
            5: begin freq = 16'd50;    abs_mm = 16'd65535; rel_q8 = 9'd0;   end
            6: begin freq = 16'd200;   abs_mm = 16'd3;     rel_q8 = 9'd64;  end
            11: begin freq = 16'd100;  abs_mm = 16'd5;     rel_q8 = 9'd128; end
            default: begin
               freq   = FREQ_W'($urandom_range(1, 2000));
               abs_mm = ABS_W'($urandom_range(0, 50));
               rel_q8 = REL_W'($urandom_range(0, 300));
            end
         endcase
         // no idling in the final phase; some phases idle on one side only
         req_idle = (phase != 11) && ($urandom_range(0, 3) != 0);
         rsp_idle = (phase != 11) && ($urandom_range(0, 3) != 0);
         set_config(freq, abs_mm, rel_q8);
         run_motion(70);
         drain_requests();
         run_motion(70);
         drain_requests();
      end
   endtask

   initial begin
      clock                = 1'b0;
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_index            = CSR_UPDATE_FREQ;
      csr_wr_data          = '0;
      req_chan.valid       = 1'b0;
      req_chan.distance_mm = '0;
      req_chan.speed_mm_s  = '0;
      rsp_chan.ready       = 1'b0;
      rsp_hold             = 1'b0;
      hold_go              = 1'b0;
      hold_cycles          = 0;
      rsp_gap_left         = 0;
      req_idle             = 1'b1;
      rsp_idle             = 1'b1;
      failures             = 0;
      responses            = 0;
      cycles               = 0;
      odometer             = '0;
      cfg_freq             = UPDATE_FREQ_RST;
      cfg_abs              = ABS_THRESH_RST;
      cfg_rel              = REL_THRESH_RST;
      speed_sum            = 0;
      slot                 = 0;
      filled               = 0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
         dist_hist[i]  = '0;
         speed_hist[i] = '0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_field_extremes();
      test_receiver_backlog();
      test_config_phases();

      drain_requests();
      repeat (16) @(posedge clock);
      if (failures == 0 && expected_flags.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d failures, %0d flags outstanding", failures, expected_flags.size());
         $display("FAILURE");
      end
      $finish;
   end
endmodule
